@@ sv/artnet_dmx_packet_receiver_macros.svh @@
// assertion macros shared by the receiver modules
`ifndef ARTNET_DMX_PACKET_RECEIVER_MACROS_SVH
`define ARTNET_DMX_PACKET_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ARTDMX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ARTDMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/artdmx_pkg.sv @@
`timescale 1ns / 1ps
package artdmx_pkg;

  localparam int POS_W     = 10;
  localparam int STORE_W   = 21;
  localparam int ADDR_W    = 20;
  localparam int TOTAL_W   = 32;
  localparam int UNIV_W    = 16;
  localparam int CFG_AW    = 2;
  localparam int CFG_DW    = 32;

  localparam int DATA_START = 18;

  localparam logic [STORE_W-1:0] STORE_RESET = 21'd6144;
  localparam logic [15:0]        ARTDMX_OPCODE = 16'h5000;

  // register byte addresses
  localparam logic [CFG_AW-1:0] REG_STORE_BYTES = 2'd0;

  // input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_COUNT  = 2'd2;

  // packet status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SHORT  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ID = 2'd2;
  localparam logic [1:0] STATUS_BAD_OP = 2'd3;

  // "Art-Net" followed by a zero byte
  localparam logic [7:0] IDENT [8] = '{8'h41, 8'h72, 8'h74, 8'h2D,
                                       8'h4E, 8'h65, 8'h74, 8'h00};

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  store_address;
    logic [7:0]         store_data;
    logic [1:0]         status_code;
    logic [TOTAL_W-1:0] packet_total;
    logic               final_result;
  } result_t;

  // results produced by one consumed item, r0 first
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

@@ sv/artdmx_parse.sv @@
`timescale 1ns / 1ps
`include "artnet_dmx_packet_receiver_macros.svh"
module artdmx_parse
  import artdmx_pkg::*;
#(
  parameter int CHANNELS_PER_UNIVERSE = 510,
  parameter int MAX_PAYLOAD_BYTES     = 530
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  logic               item_action,
  input  logic [7:0]         item_byte,
  input  logic               item_eop,
  input  logic [STORE_W-1:0] store_bytes,
  input  logic [1:0]         room,
  output logic               consume,
  output push_t              push
);

  localparam int CPU_W    = $clog2(CHANNELS_PER_UNIVERSE + 1);
  localparam int BASE_W   = UNIV_W + CPU_W;
  localparam int SUM_W    = BASE_W + 1;
  localparam int CMP_W    = (SUM_W > STORE_W) ? SUM_W : STORE_W;
  localparam int DATA_END = DATA_START + CHANNELS_PER_UNIVERSE;
  localparam logic [CMP_W-1:0] ADDR_LIMIT = CMP_W'(1) << ADDR_W;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               id_bad_r, id_bad_nxt;
  logic [7:0]         opc_lo_r, opc_lo_nxt;
  logic               opc_bad_r, opc_bad_nxt;
  logic [UNIV_W-1:0]  universe_r, universe_nxt;
  logic [TOTAL_W-1:0] count_r, count_nxt;
  logic [BASE_W-1:0]  base_r;

  logic               is_tick, in_range, is_data, addr_ok, wr_hit, do_status;
  logic [POS_W-1:0]   pos_step, offset;
  logic [SUM_W-1:0]   addr_sum;
  logic [1:0]         need, status;
  result_t            wr_res, st_res, cnt_res;

  always_comb begin
    is_tick   = (item_action == ACT_TICK);
    in_range  = (pos_r < POS_W'(MAX_PAYLOAD_BYTES));
    pos_step  = in_range ? pos_r + POS_W'(1) : pos_r;
    is_data   = in_range && (pos_r >= POS_W'(DATA_START)) && (pos_r < POS_W'(DATA_END))
                && !id_bad_r && !opc_bad_r;
    offset    = pos_r - POS_W'(DATA_START);
    addr_sum  = SUM_W'(base_r) + SUM_W'(offset);
    addr_ok   = (CMP_W'(addr_sum) < CMP_W'(store_bytes)) && (CMP_W'(addr_sum) < ADDR_LIMIT);
    wr_hit    = !is_tick && is_data && addr_ok;
    do_status = !is_tick && item_eop;

    id_bad_nxt   = id_bad_r;
    opc_lo_nxt   = opc_lo_r;
    opc_bad_nxt  = opc_bad_r;
    universe_nxt = universe_r;
    if (in_range) begin
      if (pos_r < POS_W'(8)) begin
        if (item_byte != IDENT[pos_r[2:0]]) id_bad_nxt = 1'b1;
      end else if (pos_r == POS_W'(8)) begin
        opc_lo_nxt = item_byte;
      end else if (pos_r == POS_W'(9)) begin
        if ({item_byte, opc_lo_r} != ARTDMX_OPCODE) opc_bad_nxt = 1'b1;
      end else if (pos_r == POS_W'(14)) begin
        universe_nxt = {universe_r[15:8], item_byte};
      end else if (pos_r == POS_W'(15)) begin
        universe_nxt = {item_byte, universe_r[7:0]};
      end
    end

    if (pos_step < POS_W'(DATA_START)) status = STATUS_SHORT;
    else if (id_bad_nxt)               status = STATUS_BAD_ID;
    else if (opc_bad_nxt)              status = STATUS_BAD_OP;
    else                               status = STATUS_OK;

    need    = is_tick ? 2'd1 : (2'(wr_hit) + 2'(do_status));
    consume = item_valid && (need <= room);

    wr_res               = '0;
    wr_res.kind          = KIND_WRITE;
    wr_res.store_address = addr_sum[ADDR_W-1:0];
    wr_res.store_data    = item_byte;
    wr_res.final_result  = !do_status;

    st_res              = '0;
    st_res.kind         = KIND_STATUS;
    st_res.status_code  = status;
    st_res.final_result = 1'b1;

    cnt_res              = '0;
    cnt_res.kind         = KIND_COUNT;
    cnt_res.packet_total = count_r;
    cnt_res.final_result = 1'b1;

    push.n  = consume ? need : 2'd0;
    push.r0 = is_tick ? cnt_res : (wr_hit ? wr_res : st_res);
    push.r1 = st_res;

    pos_nxt   = pos_r;
    count_nxt = count_r;
    if (consume) begin
      if (is_tick) begin
        count_nxt = '0;
      end else begin
        pos_nxt = pos_step;
        if (item_eop) begin
          pos_nxt      = '0;
          id_bad_nxt   = 1'b0;
          opc_lo_nxt   = '0;
          opc_bad_nxt  = 1'b0;
          universe_nxt = '0;
          if (status == STATUS_OK) count_nxt = count_r + TOTAL_W'(1);
        end
      end
    end else begin
      id_bad_nxt   = id_bad_r;
      opc_lo_nxt   = opc_lo_r;
      opc_bad_nxt  = opc_bad_r;
      universe_nxt = universe_r;
    end
    if (consume && is_tick) begin
      id_bad_nxt   = id_bad_r;
      opc_lo_nxt   = opc_lo_r;
      opc_bad_nxt  = opc_bad_r;
      universe_nxt = universe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      id_bad_r   <= 1'b0;
      opc_lo_r   <= '0;
      opc_bad_r  <= 1'b0;
      universe_r <= '0;
      count_r    <= '0;
    end else begin
      pos_r      <= pos_nxt;
      id_bad_r   <= id_bad_nxt;
      opc_lo_r   <= opc_lo_nxt;
      opc_bad_r  <= opc_bad_nxt;
      universe_r <= universe_nxt;
      count_r    <= count_nxt;
    end
  end

  // universe base address, settled well before the first data byte
  always_ff @(posedge clk) begin
    base_r <= BASE_W'(universe_r) * BASE_W'(CHANNELS_PER_UNIVERSE);
  end

  `ARTDMX_ASSERT_NOW(a_pair_order, push.n == 2'd2,
    push.r0.kind == KIND_WRITE && push.r1.kind == KIND_STATUS && !push.r0.final_result,
    "two results must be a write followed by a status")
  `ARTDMX_ASSERT_NEXT(a_eop_clears, consume && !is_tick && item_eop,
    pos_r == '0 && !id_bad_r && !opc_bad_r,
    "packet state not cleared after end of packet")

endmodule

@@ sv/artdmx_outq.sv @@
`timescale 1ns / 1ps
`include "artnet_dmx_packet_receiver_macros.svh"
module artdmx_outq
  import artdmx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  input  logic       out_ready,
  output logic       head_valid,
  output result_t    head,
  output logic [1:0] room
);

  result_t    slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt, cnt_after;
  logic       pop;

  always_comb begin
    pop        = (cnt_r != 2'd0) && out_ready;
    cnt_after  = cnt_r - 2'(pop);
    head_valid = (cnt_r != 2'd0);
    head       = slot0_r;
    // room from registered count only, keeps out_tready off the input side
    room       = 2'd2 - cnt_r;

    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case (cnt_after)
      2'd0: begin
        slot0_nxt = push.r0;
        slot1_nxt = push.r1;
      end
      2'd1: begin
        if (pop) slot0_nxt = slot1_r;
        slot1_nxt = push.r0;
      end
      default: ;
    endcase
    cnt_nxt = cnt_after + push.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `ARTDMX_ASSERT_NOW(a_no_overflow, push.n != 2'd0,
    ({1'b0, cnt_after} + {1'b0, push.n}) <= 3'd2, "result queue overflow")
  `ARTDMX_ASSERT_NEXT(a_drain, cnt_r == 2'd1 && pop && push.n == 2'd0,
    !head_valid, "queue not empty after last beat left")

endmodule

@@ sv/artnet_dmx_packet_receiver.sv @@
`timescale 1ns / 1ps
// path: an accepted byte is held in the input register, then the parser pushes its results into the result queue
// throughput: one input beat per cycle while the result queue has room; a data byte with the end mark gives two
//   result beats and waits until the two-entry result queue is empty
// reset: rst_n synchronous active low; clears packet state, count and queue,
//   store_bytes returns to 6144
module artnet_dmx_packet_receiver
  import artdmx_pkg::*;
#(
  parameter int CHANNELS_PER_UNIVERSE = 510,
  parameter int MAX_PAYLOAD_BYTES     = 530
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] payload_byte
  input  logic              in_tuser,   // [0] action
  input  logic              in_tlast,   // end_of_packet
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  // [19:0] store_address, [27:20] store_data, [29:28] status_code,
  // [61:30] packet_total, [63:62] zero
  output logic [63:0]       out_tdata,
  output logic [1:0]        out_tuser,  // [1:0] kind
  output logic              out_tlast,  // final_result
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // configuration register
  logic [STORE_W-1:0] store_r;
  logic               cfg_wr;

  // input register
  logic       inr_valid_r;
  logic       inr_action_r;
  logic [7:0] inr_byte_r;
  logic       inr_eop_r;

  logic       consume;
  push_t      push;
  logic [1:0] room;
  result_t    head;
  logic       head_valid;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == REG_STORE_BYTES);
  assign cfg_prdata = (cfg_paddr == REG_STORE_BYTES) ? CFG_DW'(store_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= STORE_RESET;
    end else if (cfg_wr) begin
      store_r <= cfg_pwdata[STORE_W-1:0];
    end
  end

  // input register frees as soon as the parser takes its beat
  assign in_tready = !inr_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
    end else if (in_tready) begin
      inr_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      inr_action_r <= in_tuser;
      inr_byte_r   <= in_tdata;
      inr_eop_r    <= in_tlast;
    end
  end

  // header checks, universe latch, address compute and status
  artdmx_parse #(
    .CHANNELS_PER_UNIVERSE (CHANNELS_PER_UNIVERSE),
    .MAX_PAYLOAD_BYTES     (MAX_PAYLOAD_BYTES)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (inr_valid_r),
    .item_action (inr_action_r),
    .item_byte   (inr_byte_r),
    .item_eop    (inr_eop_r),
    .store_bytes (store_r),
    .room        (room),
    .consume     (consume),
    .push        (push)
  );

  // two-entry result queue, head is the output register
  artdmx_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_ready  (out_tready),
    .head_valid (head_valid),
    .head       (head),
    .room       (room)
  );

  assign out_tvalid = head_valid;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.final_result;
  assign out_tdata  = {2'b00, head.packet_total, head.status_code,
                       head.store_data, head.store_address};

endmodule

@@ tb/artnet_dmx_packet_receiver_tb.sv @@
`timescale 1ns / 1ps
module artnet_dmx_packet_receiver_tb;
  import artdmx_pkg::*;

  // block geometry, kept equal to the defaults of the instance below
  localparam int CHANNELS  = 510;
  localparam int MAX_BYTES = 530;
  localparam logic [31:0] ADDR_SPAN = 32'h100000;

  // cycles without any beat before the run is declared hung
  localparam int QUIET_LIMIT = 4000;

  // ways a generated packet header can be damaged
  localparam int FLAW_NONE = 0;
  localparam int FLAW_ID   = 1;
  localparam int FLAW_OP   = 2;
  localparam int FLAW_BOTH = 3;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
    logic       eop;
  } rx_item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input stream, driven from the start so nothing floats
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata  = 8'h00;
  logic              in_tuser  = ACT_BYTE;
  logic              in_tlast  = 1'b0;

  // result stream
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic [1:0]        out_tuser;
  logic              out_tlast;

  // register port
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // bytes and ticks waiting to be sent, results waiting to arrive
  rx_item_t feed_q[$];
  result_t  due_beats[$];
  int       queued_total = 0;

  // percentages for the sender going idle and the receiver stalling
  int idle_pct  = 0;
  int stall_pct = 0;

  int err_count = 0;
  int quiet_cycles = 0;

  // mirror of the receiver state
  logic [9:0]  rx_pos;
  logic        id_bad;
  logic [7:0]  op_lo;
  logic        op_bad;
  logic [15:0] universe;
  logic [31:0] pkt_count;
  logic [20:0] store_limit;

  result_t head_beat;

  artnet_dmx_packet_receiver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] payload_byte
    .in_tuser   (in_tuser),    // [0] action
    .in_tlast   (in_tlast),    // end_of_packet
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [19:0] store_address, [27:20] store_data, [29:28] status_code,
    // [61:30] packet_total
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),   // [1:0] kind
    .out_tlast  (out_tlast),   // final_result
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // per-packet state goes back to zero at reset and at every packet end
  task automatic clear_packet_state();
    rx_pos   = '0;
    id_bad   = 1'b0;
    op_lo    = '0;
    op_bad   = 1'b0;
    universe = '0;
  endtask

  // works out the result beats one accepted input beat causes and queues them
  task automatic compute_receiver_outputs(input logic act, input logic [7:0] b,
                                          input logic eop);
    result_t     r0;
    result_t     r1;
    int          n;
    logic [31:0] addr;
    logic [1:0]  st;
    r0 = '0;
    r1 = '0;
    n  = 0;
    if (act == ACT_TICK) begin
      // count report, the packet in progress is left alone
      r0.kind         = KIND_COUNT;
      r0.packet_total = pkt_count;
      r0.final_result = 1'b1;
      due_beats.push_back(r0);
      pkt_count = '0;
    end else begin
      if (rx_pos < MAX_BYTES) begin
        if (rx_pos < 8) begin
          if (b != IDENT[rx_pos[2:0]]) id_bad = 1'b1;
        end else if (rx_pos == 8) begin
          op_lo = b;
        end else if (rx_pos == 9) begin
          if ({b, op_lo} != ARTDMX_OPCODE) op_bad = 1'b1;
        end else if (rx_pos == 14) begin
          universe[7:0] = b;
        end else if (rx_pos == 15) begin
          universe[15:8] = b;
        end else if (rx_pos >= DATA_START && rx_pos < DATA_START + CHANNELS &&
                     !id_bad && !op_bad) begin
          addr = universe * CHANNELS + (rx_pos - DATA_START);
          // writes past the store or past 20 address bits are dropped
          if (addr < store_limit && addr < ADDR_SPAN) begin
            r0.kind          = KIND_WRITE;
            r0.store_address = addr[ADDR_W-1:0];
            r0.store_data    = b;
            n = 1;
          end
        end
        rx_pos = rx_pos + 1'b1;
      end
      if (eop) begin
        // short first, then identifier, then opcode
        if (rx_pos < DATA_START) st = STATUS_SHORT;
        else if (id_bad) st = STATUS_BAD_ID;
        else if (op_bad) st = STATUS_BAD_OP;
        else st = STATUS_OK;
        if (st == STATUS_OK) pkt_count = pkt_count + 1;
        if (n == 0) begin
          r0.kind        = KIND_STATUS;
          r0.status_code = st;
        end else begin
          r1.kind        = KIND_STATUS;
          r1.status_code = st;
        end
        n = n + 1;
        clear_packet_state();
      end
      if (n == 1) begin
        r0.final_result = 1'b1;
        due_beats.push_back(r0);
      end else if (n == 2) begin
        r1.final_result = 1'b1;
        due_beats.push_back(r0);
        due_beats.push_back(r1);
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // driver: presents the next queued beat, going idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (feed_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= feed_q[0].action;
        in_tdata  <= feed_q[0].data;
        in_tlast  <= feed_q[0].eop;
        feed_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: predicts on each accepted input beat, checks each result beat
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      clear_packet_state();
      pkt_count   = '0;
      store_limit = STORE_RESET;
    end else begin
      if (in_tvalid && in_tready) compute_receiver_outputs(in_tuser, in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (due_beats.size() == 0) begin
          $error("result beat with nothing due: kind %0d data %h", out_tuser, out_tdata);
          err_count++;
        end else begin
          head_beat = due_beats.pop_front();
          check_field("kind", head_beat.kind, out_tuser);
          check_field("store_address", head_beat.store_address, out_tdata[19:0]);
          check_field("store_data", head_beat.store_data, out_tdata[27:20]);
          check_field("status_code", head_beat.status_code, out_tdata[29:28]);
          check_field("packet_total", head_beat.packet_total, out_tdata[61:30]);
          check_field("final_result", head_beat.final_result, out_tlast);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL artnet_dmx_packet_receiver");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic enqueue_item(input logic act, input logic [7:0] b, input logic eop);
    rx_item_t item;
    item.action = act;
    item.data   = b;
    item.eop    = eop;
    feed_q.push_back(item);
    queued_total++;
  endtask

  // tick with random ignored fields
  task automatic queue_tick();
    enqueue_item(ACT_TICK, 8'($urandom), 1'($urandom));
  endtask

  // one packet with a proper header, optionally damaged, random other bytes
  task automatic queue_packet(input int len, input logic [15:0] univ, input int flaw,
                              input bit spray);
    int         id_at;
    int         op_at;
    logic [7:0] twist;
    logic [7:0] b;
    id_at = $urandom_range(0, 7);
    op_at = $urandom_range(8, 9);
    twist = 8'($urandom_range(1, 255));
    for (int p = 0; p < len; p++) begin
      if (p < 8) b = IDENT[p];
      else if (p == 8) b = ARTDMX_OPCODE[7:0];
      else if (p == 9) b = ARTDMX_OPCODE[15:8];
      else if (p == 14) b = univ[7:0];
      else if (p == 15) b = univ[15:8];
      else b = 8'($urandom);
      if ((flaw == FLAW_ID || flaw == FLAW_BOTH) && p == id_at) b = b ^ twist;
      if ((flaw == FLAW_OP || flaw == FLAW_BOTH) && p == op_at) b = b ^ twist;
      // ticks landing in the middle of a packet
      if (spray && $urandom_range(0, 59) == 0) queue_tick();
      enqueue_item(ACT_BYTE, b, p == len - 1);
    end
  endtask

  // mostly well-formed packets, some short or damaged ones, ticks and noise
  task automatic queue_random_traffic(input int n_items);
    int          stop_at;
    int          pick;
    int          len;
    int          flaw;
    logic [15:0] univ;
    stop_at = queued_total + n_items;
    while (queued_total < stop_at) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
        0: univ = 16'($urandom);
        1: univ = 16'($urandom_range(2050, 2060));   // near the top of a full store
        default: univ = 16'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 9))
        0: flaw = FLAW_ID;
        1: flaw = FLAW_OP;
        2: flaw = FLAW_BOTH;
        default: flaw = FLAW_NONE;
      endcase
      if (pick < 8) begin
        // raw noise with end marks scattered
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++) begin
          enqueue_item(ACT_BYTE, 8'($urandom), (k == len - 1) || ($urandom_range(0, 7) == 0));
        end
      end else if (pick < 14) begin
        queue_tick();
      end else if (pick < 26) begin
        queue_packet($urandom_range(1, 17), univ, flaw, 1'b1);
      end else begin
        queue_packet(18 + $urandom_range(0, 40), univ, flaw, 1'b1);
      end
    end
  endtask

  // sender holds off until every due result is in, then the block settles
  task automatic wait_until_drained();
    while (feed_q.size() != 0 || in_tvalid || due_beats.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  // setup then access phase, register taken at the access edge
  task automatic write_store_bytes(input logic [20:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_STORE_BYTES;
    cfg_pwdata  <= CFG_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    store_limit = val;
  endtask

  initial begin
    logic [20:0] limit_val;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty count, one-byte packet, header plus two data bytes
    // with the end mark on the last data byte, then a count of one
    enqueue_item(ACT_TICK, 8'hFF, 1'b1);
    enqueue_item(ACT_BYTE, 8'h00, 1'b1);
    queue_packet(20, 16'd12, FLAW_NONE, 1'b0);
    enqueue_item(ACT_TICK, 8'h00, 1'b0);
    queue_random_traffic(210);
    wait_until_drained();

    for (int ph = 1; ph < 6; ph++) begin
      case (ph)
        1: limit_val = 21'd1048576;
        2: limit_val = 21'd0;
        3: limit_val = 21'd6200;
        4: limit_val = 21'd1;
        default: limit_val = 21'($urandom_range(0, 1048576));
      endcase
      write_store_bytes(limit_val);
      case (ph % 4)
        1: begin
          idle_pct  = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 56;
        end
        3: begin
          idle_pct  = 31;
          stall_pct = 31;
        end
        default: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
      endcase
      // overlong packet: every channel written, tail past the buffer dropped
      if (ph == 1) queue_packet($urandom_range(MAX_BYTES + 1, MAX_BYTES + 15), 16'd0,
                                FLAW_NONE, 1'b1);
      queue_random_traffic(210);
      wait_until_drained();
    end

    // catch any stray beat after the last one due
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS artnet_dmx_packet_receiver");
    end else begin
      $display("FAIL artnet_dmx_packet_receiver");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/artdmx_pkg.sv
sv/artdmx_parse.sv
sv/artdmx_outq.sv
sv/artnet_dmx_packet_receiver.sv
tb/artnet_dmx_packet_receiver_tb.sv
